@@ hw/rtl/hash_table_quadratic_probe_macros.svh @@
// ----------------------------------------------------------------------------
// hash table assertion macros
// shared concurrent assertion forms, clocked on aclk and off during reset
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_QUADRATIC_PROBE_MACROS_SVH
`define HASH_TABLE_QUADRATIC_PROBE_MACROS_SVH

// same-cycle implication
`define HTQP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HTQP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/htqp_pkg.sv @@
// ----------------------------------------------------------------------------
// htqp_pkg
// types and constants of the quadratic probing hash table
// ----------------------------------------------------------------------------
package htqp_pkg;

    localparam int CAP_W      = 11;
    localparam int COUNT_W    = 11;
    localparam int STATUS_W   = 3;
    localparam int DIGIT_BITS = 4;

    localparam logic [CAP_W-1:0]   CAP_RESET = 11'd1021;
    localparam logic [CAP_W-1:0]   CAP_MIN   = 11'd2;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_NO_FREE   = 3'd4
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_LOOKUP = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PROBE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             done;
        logic [CAP_W-1:0] rem;
    } mod_result_t;

endpackage

@@ hw/rtl/htqp_mod_unit.sv @@
// ----------------------------------------------------------------------------
// htqp_mod_unit
// key modulo capacity, restoring remainder, DIGIT_BITS dividend bits a cycle
// ----------------------------------------------------------------------------
module htqp_mod_unit #(
    parameter int KEY_BITS = 31
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [KEY_BITS-1:0]            dividend,
    input  logic [htqp_pkg::CAP_W-1:0]     divisor,
    output htqp_pkg::mod_result_t          result
);

    localparam int DB    = htqp_pkg::DIGIT_BITS;
    localparam int CW    = htqp_pkg::CAP_W;
    localparam int STEPS = (KEY_BITS + DB - 1) / DB;
    localparam int PAD_W = STEPS * DB;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [PAD_W-1:0] sh_reg;
    logic [CW-1:0]    rem_reg;
    logic [CW-1:0]    div_reg;
    logic [CW-1:0]    rem_next;

    always_comb begin
        logic [CW:0] r;
        r = {1'b0, rem_reg};
        for (int b = 0; b < DB; b++) begin
            r = {r[CW-1:0], sh_reg[PAD_W-1-b]};
            if (r >= {1'b0, div_reg}) begin
                r = r - {1'b0, div_reg};
            end
        end
        rem_next = r[CW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_reg  <= PAD_W'(dividend);
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            sh_reg  <= sh_reg << DB;
            rem_reg <= rem_next;
        end
    end

    assign result.done = done_reg;
    assign result.rem  = rem_reg;

endmodule

@@ hw/rtl/hash_table_quadratic_probe.sv @@
// ----------------------------------------------------------------------------
// hash_table_quadratic_probe
// open addressing hash table, insert and look up, quadratic probe sequence
// ----------------------------------------------------------------------------
// path: input beat, key modulo unit, probes through the slot memory, result
//   registers, output registers; s_ready is low from the accepted beat until
//   the result moves to the output registers; pace set by the key modulo unit
//   and one probe a cycle through the single slot memory
// reset: clears a sweep over all TABLE_DEPTH slots of the slot memory with
//   s_ready low; capacity returns to 1021, used count to zero
// ----------------------------------------------------------------------------
`include "hash_table_quadratic_probe_macros.svh"

module hash_table_quadratic_probe #(
    parameter int  TABLE_DEPTH = 1024,
    parameter int  KEY_BITS    = 31,
    localparam int ADDR_W      = $clog2(TABLE_DEPTH)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [htqp_pkg::CAP_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [KEY_BITS-1:0]               s_key,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [htqp_pkg::STATUS_W-1:0]     m_status,
    output logic [ADDR_W-1:0]                 m_slot,
    output logic [htqp_pkg::COUNT_W-1:0]      m_occupied_count,
    output logic                              m_load_over_half
);

    localparam int CW = htqp_pkg::CAP_W;
    localparam int NW = htqp_pkg::COUNT_W;

    htqp_pkg::state_t       state_reg, state_next;
    logic [CW-1:0]          cap_reg, cap_next;
    logic [CW-1:0]          cap_eff;
    logic [CW-1:0]          cap_q_reg, cap_q_next;
    htqp_pkg::action_t      act_reg, act_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic [CW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          inc_reg, inc_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   rdv_reg, rdv_next;
    logic [CW-1:0]          pos_q_reg, pos_q_next;
    logic                   last_q_reg, last_q_next;
    logic [NW-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]      clr_reg, clr_next;
    htqp_pkg::status_t      res_status_reg, res_status_next;
    logic [ADDR_W-1:0]      res_slot_reg, res_slot_next;
    logic [NW-1:0]          res_count_reg, res_count_next;
    logic                   res_half_reg, res_half_next;
    logic                   m_valid_reg, m_valid_next;
    htqp_pkg::status_t      m_status_reg, m_status_next;
    logic [ADDR_W-1:0]      m_slot_reg, m_slot_next;
    logic [NW-1:0]          m_count_reg, m_count_next;
    logic                   m_half_reg, m_half_next;

    logic [KEY_BITS:0]      mem [TABLE_DEPTH];
    logic [KEY_BITS:0]      rd_q;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_wa;
    logic [KEY_BITS:0]      mem_wd;
    logic [ADDR_W-1:0]      mem_ra;

    logic                   div_start;
    htqp_pkg::mod_result_t  div_res;

    logic [CW:0]            pos_sum, inc_sum;
    logic [CW-1:0]          pos_adv, inc_adv;
    logic                   rd_used, hit, issue, finish;
    logic [NW-1:0]          count_new;

    htqp_mod_unit #(
        .KEY_BITS (KEY_BITS)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_key),
        .divisor  (cap_eff),
        .result   (div_res)
    );

    // clamp the capacity register to 2..TABLE_DEPTH
    always_comb begin
        if (cap_reg < htqp_pkg::CAP_MIN) begin
            cap_eff = htqp_pkg::CAP_MIN;
        end else if (32'(cap_reg) > 32'(TABLE_DEPTH)) begin
            cap_eff = CW'(TABLE_DEPTH);
        end else begin
            cap_eff = cap_reg;
        end
    end

    // next probe position and step, the step growing by two, both kept below the capacity
    always_comb begin
        pos_sum = {1'b0, pos_reg} + {1'b0, inc_reg};
        pos_adv = (pos_sum >= {1'b0, cap_q_reg}) ? CW'(pos_sum - {1'b0, cap_q_reg})
                                                 : pos_sum[CW-1:0];
        inc_sum = {1'b0, inc_reg} + (CW+1)'(2);
        inc_adv = (inc_sum >= {1'b0, cap_q_reg}) ? CW'(inc_sum - {1'b0, cap_q_reg})
                                                 : inc_sum[CW-1:0];
    end

    assign rd_used   = rd_q[KEY_BITS];
    assign hit       = !rd_used || (rd_q[KEY_BITS-1:0] == key_reg);
    assign issue     = (state_reg == htqp_pkg::S_PROBE) && (idx_reg < cap_q_reg);
    assign finish    = (state_reg == htqp_pkg::S_PROBE) && rdv_reg && (hit || last_q_reg);
    assign count_new = (count_reg < htqp_pkg::COUNT_MAX) ? count_reg + NW'(1) : count_reg;
    assign div_start = s_valid && s_ready;

    always_comb begin
        state_next      = state_reg;
        cap_next        = cfg_wr_en ? cfg_wr_data : cap_reg;
        cap_q_next      = cap_q_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        pos_next        = pos_reg;
        inc_next        = inc_reg;
        idx_next        = idx_reg;
        rdv_next        = 1'b0;
        pos_q_next      = pos_q_reg;
        last_q_next     = last_q_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_count_next  = res_count_reg;
        res_half_next   = res_half_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_slot_next     = m_slot_reg;
        m_count_next    = m_count_reg;
        m_half_next     = m_half_reg;
        mem_we          = 1'b0;
        mem_wa          = ADDR_W'(pos_q_reg);
        mem_wd          = {1'b1, key_reg};
        mem_ra          = ADDR_W'(pos_reg);
        s_ready         = 1'b0;

        unique case (state_reg)
            htqp_pkg::S_CLEAR: begin
                mem_we   = 1'b1;
                mem_wa   = clr_reg;
                mem_wd   = '0;
                clr_next = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(TABLE_DEPTH - 1)) begin
                    state_next = htqp_pkg::S_IDLE;
                end
            end
            htqp_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    act_next   = htqp_pkg::action_t'(s_action);
                    key_next   = s_key;
                    cap_q_next = cap_eff;
                    state_next = htqp_pkg::S_DIV;
                end
            end
            htqp_pkg::S_DIV: begin
                if (div_res.done) begin
                    pos_next   = div_res.rem;
                    inc_next   = CW'(1);
                    idx_next   = '0;
                    state_next = htqp_pkg::S_PROBE;
                end
            end
            htqp_pkg::S_PROBE: begin
                rdv_next = issue;
                if (issue) begin
                    pos_q_next  = pos_reg;
                    last_q_next = (idx_reg == cap_q_reg - CW'(1));
                    pos_next    = pos_adv;
                    inc_next    = inc_adv;
                    idx_next    = idx_reg + CW'(1);
                end
                if (finish) begin
                    rdv_next       = 1'b0;
                    state_next     = htqp_pkg::S_DONE;
                    res_slot_next  = hit ? ADDR_W'(pos_q_reg) : '0;
                    res_count_next = count_reg;
                    if (act_reg == htqp_pkg::ACT_LOOKUP) begin
                        res_status_next = (hit && rd_used) ? htqp_pkg::ST_FOUND
                                                           : htqp_pkg::ST_NOT_FOUND;
                    end else if (!hit) begin
                        res_status_next = htqp_pkg::ST_NO_FREE;
                    end else if (rd_used) begin
                        res_status_next = htqp_pkg::ST_PRESENT;
                    end else begin
                        res_status_next = htqp_pkg::ST_INSERTED;
                        mem_we          = 1'b1;
                        count_next      = count_new;
                        res_count_next  = count_new;
                    end
                    res_half_next = (res_count_next > NW'(cap_q_reg >> 1));
                end
            end
            htqp_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_slot_next   = res_slot_reg;
                    m_count_next  = res_count_reg;
                    m_half_next   = res_half_reg;
                    state_next    = htqp_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = htqp_pkg::S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= htqp_pkg::S_CLEAR;
            cap_reg     <= htqp_pkg::CAP_RESET;
            count_reg   <= '0;
            clr_reg     <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cap_reg     <= cap_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cap_q_reg      <= cap_q_next;
        act_reg        <= act_next;
        key_reg        <= key_next;
        pos_reg        <= pos_next;
        inc_reg        <= inc_next;
        idx_reg        <= idx_next;
        pos_q_reg      <= pos_q_next;
        last_q_reg     <= last_q_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_count_reg  <= res_count_next;
        res_half_reg   <= res_half_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
        m_count_reg    <= m_count_next;
        m_half_reg     <= m_half_next;
    end

    // slot memory, used mark on top of the key
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_q <= mem[mem_ra];
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_slot           = m_slot_reg;
    assign m_occupied_count = m_count_reg;
    assign m_load_over_half = m_half_reg;

    `HTQP_ASSERT_IMP(a_probe_in_range, state_reg == htqp_pkg::S_PROBE, (pos_reg < cap_q_reg) && (inc_reg < cap_q_reg), "probe position or step out of range")
    `HTQP_ASSERT_IMP(a_write_sets_mark, mem_we && (state_reg != htqp_pkg::S_CLEAR), mem_wd[KEY_BITS] && (mem_wa == ADDR_W'(pos_q_reg)), "insert write not at probed slot")
    `HTQP_ASSERT_NXT(a_count_monotonic, 1'b1, count_reg >= $past(count_reg), "used count decreased")
    `HTQP_ASSERT_IMP(a_result_from_done, $rose(m_valid_reg), $past(state_reg) == htqp_pkg::S_DONE, "result beat without finished item")

endmodule
